// ===== hdl/lzwe_pkg.sv =====
// Package for the LZW tree dictionary encoder.
// Holds the transaction types and the fixed LZW codes; no dependencies.
package lzwe_pkg;

  localparam int CODE_W = 12;
  localparam int ROOT_NODES = 256;

  localparam logic [CODE_W-1:0] CODE_CLEAR = 12'd256;
  localparam logic [CODE_W-1:0] CODE_EOI = 12'd257;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_strip;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_strip;
  } out_item_t;

endpackage

// ===== hdl/lzwe_fifo.sv =====
// Small synchronous queue used in front of and behind the encoder core.
// Standalone; no package dependency.
module lzwe_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_nxt = do_push ? wr_r + AW'(1) : wr_r;
    rd_nxt = do_pop ? rd_r + AW'(1) : rd_r;
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

// ===== hdl/lzwe_core.sv =====
// Encoder back end: dictionary tree search, node insertion and code packing.
// Depends on lzwe_pkg; fed and drained through lzwe_fifo queues.
module lzwe_core
  import lzwe_pkg::*;
#(
  parameter int TABLE_NODES = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_empty,
  output logic      in_pop,
  input  in_item_t  in_item,
  input  logic      out_full,
  output logic      out_push,
  output out_item_t out_item
);

  localparam int NB = $clog2(TABLE_NODES);
  localparam int MW = 8 + 3 * NB;

  typedef enum logic [4:0] {
    S_IDLE, S_OPEN, S_EXT, S_RD, S_CMP, S_MK1, S_MK2, S_FULL, S_FULL2, S_FULL3,
    S_LAST, S_EOI, S_FLUSH, S_FLUSH2, S_SEND, S_PUT1, S_PUT2
  } state_t;

  typedef enum logic [1:0] {F_CHILD, F_LO, F_HI} fld_t;

  state_t          state_r, state_nxt, ret_r, ret_nxt;
  fld_t            fld_r, fld_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            last_r, last_nxt;
  logic [NB-1:0]   cur_r, cur_nxt, addr_r, addr_nxt, nfree_r, nfree_nxt;
  logic            act_r, act_nxt, open_r, open_nxt, tree_r, tree_nxt;
  logic [31:0]     buf_r, buf_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [ROOT_NODES-1:0] rvld_r, rvld_nxt;

  logic [MW-1:0]   mem [TABLE_NODES];
  logic [MW-1:0]   q_r;
  logic            mem_re, mem_we;
  logic [NB-1:0]   mem_wa;
  logic [MW-1:0]   mem_wd;

  logic [7:0]      q_val;
  logic [NB-1:0]   q_lo, q_hi, q_child, link;
  logic            is_root;
  logic [CODE_W-1:0] nf12, mask;
  logic [3:0]      w_c;
  logic [5:0]      sh;
  logic [4:0]      cnt_sum;

  function automatic logic [CODE_W-1:0] code_of(input logic [NB-1:0] n);
    logic [CODE_W-1:0] c;
    c = CODE_W'(n);
    return (c < CODE_W'(ROOT_NODES)) ? c : c + CODE_W'(2);
  endfunction

  assign q_val = q_r[MW-1 -: 8];
  assign q_lo = q_r[3*NB-1 -: NB];
  assign q_hi = q_r[2*NB-1 -: NB];
  assign q_child = q_r[NB-1:0];
  assign is_root = (addr_r[NB-1:8] == '0);
  assign link = (is_root && !rvld_r[addr_r[7:0]]) ? '0 : q_child;

  assign nf12 = CODE_W'(nfree_r);
  assign w_c = (nf12 <= 12'd510) ? 4'd9 : (nf12 <= 12'd1022) ? 4'd10 :
               (nf12 <= 12'd2046) ? 4'd11 : 4'd12;
  assign mask = 12'hfff >> (4'd12 - w_c);
  assign sh = 6'd32 - 6'(w_c) - 6'(cnt_r);
  assign cnt_sum = cnt_r + 5'(w_c);

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    fld_nxt = fld_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    cur_nxt = cur_r;
    addr_nxt = addr_r;
    nfree_nxt = nfree_r;
    act_nxt = act_r;
    open_nxt = open_r;
    tree_nxt = tree_r;
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    code_nxt = code_r;
    rvld_nxt = rvld_r;
    in_pop = 1'b0;
    out_push = 1'b0;
    out_item = '{out_byte: buf_r[31:24], last_of_strip: 1'b0};
    mem_re = 1'b0;
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = q_r;
    unique case (state_r)
      S_IDLE: begin
        if (!in_empty) begin
          in_pop = 1'b1;
          byte_nxt = in_item.data_byte;
          last_nxt = in_item.end_of_strip;
          state_nxt = open_r ? S_EXT : S_OPEN;
        end
      end
      S_OPEN: begin
        rvld_nxt = '0;
        nfree_nxt = NB'(ROOT_NODES);
        buf_nxt = '0;
        cnt_nxt = '0;
        act_nxt = 1'b0;
        cur_nxt = '0;
        open_nxt = 1'b1;
        code_nxt = CODE_CLEAR;
        ret_nxt = S_EXT;
        state_nxt = S_SEND;
      end
      S_EXT: begin
        if (!act_r) begin
          cur_nxt = NB'(byte_r);
          act_nxt = 1'b1;
          state_nxt = S_FULL;
        end else begin
          addr_nxt = cur_r;
          tree_nxt = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mem_re = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!tree_r) begin
          if (link == '0) begin
            fld_nxt = F_CHILD;
            state_nxt = S_MK1;
          end else begin
            addr_nxt = link;
            tree_nxt = 1'b1;
            state_nxt = S_RD;
          end
        end else if (byte_r == q_val) begin
          cur_nxt = addr_r;
          state_nxt = S_FULL;
        end else if (byte_r < q_val) begin
          if (q_lo == '0) begin
            fld_nxt = F_LO;
            state_nxt = S_MK1;
          end else begin
            addr_nxt = q_lo;
            state_nxt = S_RD;
          end
        end else begin
          if (q_hi == '0) begin
            fld_nxt = F_HI;
            state_nxt = S_MK1;
          end else begin
            addr_nxt = q_hi;
            state_nxt = S_RD;
          end
        end
      end
      S_MK1: begin
        mem_we = 1'b1;
        mem_wa = nfree_r;
        mem_wd = {byte_r, {(3*NB){1'b0}}};
        state_nxt = S_MK2;
      end
      S_MK2: begin
        mem_we = 1'b1;
        unique case (fld_r)
          F_CHILD: begin
            mem_wd[NB-1:0] = nfree_r;
            if (is_root) begin
              rvld_nxt[addr_r[7:0]] = 1'b1;
            end
          end
          F_LO: mem_wd[3*NB-1 -: NB] = nfree_r;
          F_HI: mem_wd[2*NB-1 -: NB] = nfree_r;
          default: mem_we = 1'b0;
        endcase
        nfree_nxt = nfree_r + NB'(1);
        code_nxt = code_of(cur_r);
        cur_nxt = NB'(byte_r);
        ret_nxt = S_FULL;
        state_nxt = S_SEND;
      end
      S_FULL: begin
        if ({1'b0, nfree_r} > (NB+1)'(TABLE_NODES - 3)) begin
          code_nxt = code_of(cur_r);
          ret_nxt = S_FULL2;
          state_nxt = S_SEND;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_FULL2: begin
        code_nxt = CODE_CLEAR;
        ret_nxt = S_FULL3;
        state_nxt = S_SEND;
      end
      S_FULL3: begin
        rvld_nxt = '0;
        nfree_nxt = NB'(ROOT_NODES);
        act_nxt = 1'b0;
        cur_nxt = '0;
        state_nxt = S_LAST;
      end
      S_LAST: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (act_r) begin
          code_nxt = code_of(cur_r);
          ret_nxt = S_EOI;
          state_nxt = S_SEND;
        end else begin
          state_nxt = S_EOI;
        end
      end
      S_EOI: begin
        code_nxt = CODE_EOI;
        ret_nxt = S_FLUSH;
        state_nxt = S_SEND;
      end
      S_FLUSH: begin
        out_item.last_of_strip = (cnt_r <= 5'd8);
        if (!out_full) begin
          out_push = 1'b1;
          if (cnt_r > 5'd8) begin
            state_nxt = S_FLUSH2;
          end else begin
            buf_nxt = '0;
            cnt_nxt = '0;
            act_nxt = 1'b0;
            open_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH2: begin
        out_item = '{out_byte: buf_r[23:16], last_of_strip: 1'b1};
        if (!out_full) begin
          out_push = 1'b1;
          buf_nxt = '0;
          cnt_nxt = '0;
          act_nxt = 1'b0;
          open_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_SEND: begin
        buf_nxt = buf_r | (32'(code_r & mask) << sh);
        cnt_nxt = cnt_sum;
        state_nxt = (cnt_sum > 5'd16) ? S_PUT1 : ret_r;
      end
      S_PUT1: begin
        if (!out_full) begin
          out_push = 1'b1;
          state_nxt = S_PUT2;
        end
      end
      S_PUT2: begin
        out_item.out_byte = buf_r[23:16];
        if (!out_full) begin
          out_push = 1'b1;
          buf_nxt = buf_r << 16;
          cnt_nxt = cnt_r - 5'd16;
          state_nxt = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      cur_r <= '0;
      nfree_r <= NB'(ROOT_NODES);
      act_r <= 1'b0;
      open_r <= 1'b0;
      buf_r <= '0;
      cnt_r <= '0;
      rvld_r <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      cur_r <= cur_nxt;
      nfree_r <= nfree_nxt;
      act_r <= act_nxt;
      open_r <= open_nxt;
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
      rvld_r <= rvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fld_r <= fld_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    addr_r <= addr_nxt;
    tree_r <= tree_nxt;
    code_r <= code_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      q_r <= mem[addr_r];
    end
  end

`ifndef SYNTHESIS
  a_nfree_floor: assert property (@(posedge clk) disable iff (!rst_n)
    nfree_r >= NB'(ROOT_NODES)) else $error("free node pointer below root nodes");
  a_idle_bits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> cnt_r <= 5'd16) else $error("too many pending bits");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full) else $error("push into full result queue");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_pop |=> state_r == S_EXT || state_r == S_OPEN) else $error("bad item start");
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_push && out_item.last_of_strip |=> cnt_r == '0 && !open_r)
    else $error("strip not closed after last byte");
`endif

endmodule

// ===== hdl/lzw_tree_dictionary_encoder.sv =====
// LZW encoder for 12-bit TIFF-style strips with a binary-tree dictionary.
// The input queue feeds the item to the back end, which writes to the result queue.
// Usage:
//   Input channel: in_data_byte and in_end_of_strip are taken when in_push is
//   high and in_full is low. The first byte after reset or after an end-of-strip
//   opens a new strip and sends a clear code first.
//   Result channel: while out_empty is low, out_byte and out_last_of_strip show
//   the oldest packed byte; it leaves on a cycle with out_pop high.
//   out_last_of_strip marks the final byte of each strip.
// Processing:
//   Each byte takes registered dictionary reads: one for the current node's
//   child link and one per sibling-tree node visited (none when it starts the
//   first string after a strip opens or the dictionary clears). A miss adds a
//   node insertion and a packed code; each pair of bytes written out is a
//   further step. The next byte is taken only once the last one is through.
// Reset: synchronous, active low; the queues empty and the next byte opens a
// strip. No clearing pass is needed: root links carry valid bits and newer
// nodes are always written before they are read.
// Stall: when the result queue fills, the back end waits and the input queue
// fills behind it, raising in_full.
module lzw_tree_dictionary_encoder
  import lzwe_pkg::*;
#(
  parameter int TABLE_NODES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_strip,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_last_of_strip
);

  in_item_t  in_din, in_dout;
  out_item_t out_din, out_dout;
  logic      q_empty, q_pop, r_full, r_push;

  assign in_din = '{data_byte: in_data_byte, end_of_strip: in_end_of_strip};

  lzwe_fifo #(.WIDTH($bits(in_item_t)), .DEPTH(2)) u_in_q (
    .clk(clk), .rst_n(rst_n),
    .push(in_push), .full(in_full), .din(in_din),
    .pop(q_pop), .empty(q_empty), .dout(in_dout)
  );

  lzwe_core #(.TABLE_NODES(TABLE_NODES)) u_core (
    .clk(clk), .rst_n(rst_n),
    .in_empty(q_empty), .in_pop(q_pop), .in_item(in_dout),
    .out_full(r_full), .out_push(r_push), .out_item(out_din)
  );

  lzwe_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(4)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(r_push), .full(r_full), .din(out_din),
    .pop(out_pop), .empty(out_empty), .dout(out_dout)
  );

  assign out_byte = out_dout.out_byte;
  assign out_last_of_strip = out_dout.last_of_strip;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for lzw_tree_dictionary_encoder.
// Predicts the packed LZW byte stream of each strip and compares every popped byte.
// Depends on lzwe_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module tb_top
  import lzwe_pkg::*;
();

  localparam int NODES = 4096;

  class lzw_stream_board;
    bit [7:0]  val [NODES];
    bit [11:0] lo [NODES];
    bit [11:0] hi [NODES];
    bit [11:0] child [NODES];
    int unsigned nfree;
    int unsigned cur;
    bit active;
    bit [31:0] bits;
    int unsigned nbits;
    bit open;
    int nres;
    int errors;
    out_item_t pending[$];

    function new();
      table_init();
      cur = 0;
      active = 0;
      bits = 0;
      nbits = 0;
      open = 0;
      errors = 0;
    endfunction

    function void table_init();
      for (int i = 0; i < NODES; i++) begin
        val[i] = (i < 256) ? i[7:0] : 8'd0;
        lo[i] = 0;
        hi[i] = 0;
        child[i] = 0;
      end
      nfree = 256;
    endfunction

    function void put_byte(bit [7:0] b);
      out_item_t it;
      it.out_byte = b;
      it.last_of_strip = 1'b0;
      pending.push_back(it);
      nres++;
    endfunction

    function void send_code(int unsigned code);
      int unsigned w;
      if (nfree <= 510) w = 9;
      else if (nfree <= 1022) w = 10;
      else if (nfree <= 2046) w = 11;
      else w = 12;
      code &= (1 << w) - 1;
      nbits &= 31;
      if (nbits > 16) nbits = 16;
      bits |= 32'(code << (32 - w - nbits));
      nbits += w;
      if (nbits > 16) begin
        put_byte(bits[31:24]);
        put_byte(bits[23:16]);
        bits = bits << 16;
        nbits -= 16;
      end
    endfunction

    function int unsigned code_of(int unsigned n);
      return (n < 256) ? n : n + 2;
    endfunction

    function int unsigned add_node(bit [7:0] b);
      int unsigned n;
      n = nfree;
      if (n >= NODES) n = NODES - 1;
      val[n] = b;
      lo[n] = 0;
      hi[n] = 0;
      child[n] = 0;
      nfree = (nfree + 1) & 12'hfff;
      return n;
    endfunction

    function bit extend(bit [7:0] b);
      int unsigned c;
      c = cur % NODES;
      if (child[c] == 0) begin
        child[c] = 12'(add_node(b));
        return 0;
      end
      c = child[c];
      for (int s = 0; s < NODES; s++) begin
        if (b == val[c]) begin
          cur = c;
          return 1;
        end
        if (b < val[c]) begin
          if (lo[c] == 0) begin
            lo[c] = 12'(add_node(b));
            return 0;
          end
          c = lo[c];
        end else begin
          if (hi[c] == 0) begin
            hi[c] = 12'(add_node(b));
            return 0;
          end
          c = hi[c];
        end
      end
      cur = c;
      return 1;
    endfunction

    function void note_byte(bit [7:0] b, bit eos);
      int unsigned prev;
      nres = 0;
      if (!open) begin
        table_init();
        bits = 0;
        nbits = 0;
        active = 0;
        cur = 0;
        open = 1;
        send_code(CODE_CLEAR);
      end
      if (!active) begin
        cur = b;
        active = 1;
      end else begin
        prev = cur;
        if (!extend(b)) begin
          send_code(code_of(prev));
          cur = b;
        end
      end
      if (nfree > NODES - 3) begin
        send_code(code_of(cur));
        send_code(CODE_CLEAR);
        table_init();
        active = 0;
        cur = 0;
      end
      if (eos) begin
        if (active) send_code(code_of(cur));
        send_code(CODE_EOI);
        if (nbits > 0) put_byte(bits[31:24]);
        if (nbits > 8) put_byte(bits[23:16]);
        bits = 0;
        nbits = 0;
        if (nres > 0) pending[$].last_of_strip = 1'b1;
        active = 0;
        open = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_byte(bit [7:0] b, bit last);
      out_item_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", b, last));
        return;
      end
      e = pending.pop_front();
      if (b != e.out_byte)
        report($sformatf("out_byte %02h, predicted %02h", b, e.out_byte));
      if (last != e.last_of_strip)
        report($sformatf("last_of_strip %0b, predicted %0b", last, e.last_of_strip));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_full;
  logic [7:0] in_data_byte = 0;
  logic in_end_of_strip = 0;
  logic out_empty;
  logic out_pop = 0;
  logic [7:0] out_byte;
  logic out_last_of_strip;

  lzw_stream_board sb = new();
  bit calm = 0;
  int hold_cycles = 0;

  lzw_tree_dictionary_encoder u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_data_byte(in_data_byte), .in_end_of_strip(in_end_of_strip),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_byte(out_byte), .out_last_of_strip(out_last_of_strip)
  );

  always #10 clk = ~clk;

  task push_byte(bit [7:0] b, bit eos);
    in_push <= 1'b1;
    in_data_byte <= b;
    in_end_of_strip <= eos;
    do @(posedge clk); while (in_full);
    sb.note_byte(b, eos);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task push_strip(int len, bit narrow);
    for (int i = 0; i < len; i++)
      push_byte(narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255)), i == len - 1);
  endtask

  initial begin
    @(posedge clk);
    while (1) begin
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_byte(out_byte, out_last_of_strip);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= rst_n && (calm || $urandom_range(0, 99) >= 20);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[lzw_tree_dictionary_encoder] ERROR");
    $finish;
  end

  initial begin
    int n;
    string abab;
    abab = "ABABABA";
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    push_byte(8'h00, 1);
    push_byte(8'hff, 1);
    for (int i = 0; i < 7; i++) push_byte(abab[i], i == 6);
    for (int i = 0; i < 8; i++) push_byte((i % 2) ? 8'hff : 8'h00, i == 7);
    push_byte(8'h55, 0);
    push_byte(8'h55, 0);
    push_byte(8'haa, 1);
    n = 0;
    while (n < 380) begin
      int len;
      len = $urandom_range(1, 30);
      if (n >= 100 && n < 130) hold_cycles = 600;
      calm = (n >= 250 && n < 330);
      if (n >= 200 && n < 230) begin
        in_push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      push_strip(len, 1'($urandom_range(0, 1)));
      n += len;
    end
    calm = 0;
    push_strip(20, 0);
    in_push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("[lzw_tree_dictionary_encoder] OK");
    else
      $display("[lzw_tree_dictionary_encoder] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lzwe_pkg.sv
hdl/lzwe_fifo.sv
hdl/lzwe_core.sv
hdl/lzw_tree_dictionary_encoder.sv
tb/tb_top.sv
